>>> sv/tdsrv_pkg.sv
// Shared types and constants for the row value deframer.
// No dependencies; imported by tdsrv_step and tds_row_value_deframer.
`timescale 1ns / 1ps
`default_nettype none
package tdsrv_pkg;

   localparam int unsigned COL_W      = 5;
   localparam int unsigned COUNT_W    = 6;
   localparam int unsigned LEN_W      = 16;
   localparam int unsigned CLASS_W    = 4;
   localparam int unsigned TABLE_W    = 64;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [LEN_W-1:0] LEN_NULL  = 16'hFFFF;
   localparam logic [LEN_W-1:0] GUID_LEN  = 16'd16;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_LOW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_HIGH   = 2'd2;

   // format classes
   localparam logic [CLASS_W-1:0] CLS_FIXED1  = 4'd0;
   localparam logic [CLASS_W-1:0] CLS_FIXED2  = 4'd1;
   localparam logic [CLASS_W-1:0] CLS_FIXED4  = 4'd2;
   localparam logic [CLASS_W-1:0] CLS_FIXED8  = 4'd3;
   localparam logic [CLASS_W-1:0] CLS_PREFIX1 = 4'd4;
   localparam logic [CLASS_W-1:0] CLS_PREFIX2 = 4'd5;
   localparam logic [CLASS_W-1:0] CLS_GUID    = 4'd6;

   typedef enum logic [1:0] {
      KIND_VALUE = 2'd0,
      KIND_NULL  = 2'd1,
      KIND_EMPTY = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_START       = 3'b001,
      PH_PREFIX_HIGH = 3'b010,
      PH_PAYLOAD     = 3'b100
   } phase_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      phase_type        phase;
      logic [LEN_W-1:0] bytes_left;
      logic [7:0]       prefix_low;
      logic             error;
   } parse_state_type;

   typedef struct packed {
      logic             valid;
      kind_type         kind;
      logic [7:0]       value_byte;
      logic [COL_W-1:0] column_index;
      logic             last_of_value;
      logic             last_of_row;
   } result_type;

endpackage
`default_nettype wire

>>> sv/tdsrv_step.sv
// Per-byte parse step: next parser state and the optional result for one byte.
// Depends on tdsrv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tdsrv_step
   import tdsrv_pkg::*;
(
   input  wire parse_state_type     cur,
   input  wire logic [7:0]          data_byte,
   input  wire logic [CLASS_W-1:0]  col_class,
   input  wire logic [COUNT_W-1:0]  eff_count,
   output parse_state_type          nxt,
   output result_type               res
);

   logic [COUNT_W-1:0] col_plus_one;
   logic               row_end;
   logic [LEN_W-1:0]   prefix_len;
   logic               finish;
   kind_type           finish_kind;
   logic [7:0]         finish_byte;

   assign col_plus_one = {1'b0, cur.column} + COUNT_W'(1);
   assign row_end      = col_plus_one >= eff_count;
   assign prefix_len   = {data_byte, cur.prefix_low};

   always_comb begin
      nxt         = cur;
      res         = '0;
      res.kind    = KIND_VALUE;
      res.column_index = cur.column;
      finish      = 1'b0;
      finish_kind = KIND_VALUE;
      finish_byte = 8'd0;

      if (!cur.error) begin
         unique case (cur.phase)
            PH_PAYLOAD: begin
               if (cur.bytes_left <= LEN_W'(1)) begin
                  finish      = 1'b1;
                  finish_byte = data_byte;
               end else begin
                  nxt.bytes_left = cur.bytes_left - LEN_W'(1);
                  res.valid      = 1'b1;
                  res.value_byte = data_byte;
               end
            end
            PH_PREFIX_HIGH: begin
               if (prefix_len == LEN_NULL) begin
                  finish      = 1'b1;
                  finish_kind = KIND_NULL;
               end else if (prefix_len == '0) begin
                  finish      = 1'b1;
                  finish_kind = KIND_EMPTY;
               end else begin
                  nxt.phase      = PH_PAYLOAD;
                  nxt.bytes_left = prefix_len;
               end
            end
            default: begin
               // start of column; unused phase codes land here too
               case (col_class) inside
                  CLS_FIXED1: begin
                     finish      = 1'b1;
                     finish_byte = data_byte;
                  end
                  CLS_FIXED2, CLS_FIXED4, CLS_FIXED8: begin
                     nxt.phase      = PH_PAYLOAD;
                     nxt.bytes_left = (LEN_W'(1) << col_class) - LEN_W'(1);
                     res.valid      = 1'b1;
                     res.value_byte = data_byte;
                  end
                  CLS_PREFIX1, CLS_GUID: begin
                     if (data_byte == 8'd0) begin
                        finish      = 1'b1;
                        finish_kind = KIND_NULL;
                     end else begin
                        nxt.phase      = PH_PAYLOAD;
                        nxt.bytes_left = (col_class == CLS_GUID) ? GUID_LEN
                                                                 : LEN_W'(data_byte);
                     end
                  end
                  CLS_PREFIX2: begin
                     nxt.prefix_low = data_byte;
                     nxt.phase      = PH_PREFIX_HIGH;
                  end
                  default: begin
                     // unsupported class: report once, then drop everything
                     res.valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     nxt.error      = 1'b1;
                     nxt.phase      = PH_START;
                     nxt.bytes_left = '0;
                  end
               endcase
            end
         endcase

         if (finish) begin
            res.valid         = 1'b1;
            res.kind          = finish_kind;
            res.value_byte    = finish_byte;
            res.last_of_value = 1'b1;
            res.last_of_row   = row_end;
            nxt.column        = row_end ? '0 : col_plus_one[COL_W-1:0];
            nxt.phase         = PH_START;
            nxt.bytes_left    = '0;
         end
      end
   end

endmodule
`default_nettype wire

>>> sv/tds_row_value_deframer.sv
// Top level of the row value deframer: configuration registers, parser state,
// result register. Depends on tdsrv_pkg and tdsrv_step.
//
// Usage:
//  - req_ channel: one raw row byte per beat (req_data_byte).
//  - rsp_ channel: at most one result per input byte: a value byte, a null
//    or empty marker, or a single unsupported-class error, each tagged with
//    its column and end-of-value / end-of-row flags. Prefix bytes that do not
//    end a column give no result.
//  - csr_ channel: register writes (0 column count, 1 class table for
//    columns 0..15, 2 class table for columns 16..31); always ready. Write
//    only while the block is idle.
//  - Throughput: one byte per cycle while req_ready is high. Parser state is
//    updated in the accept cycle; a byte's result is on rsp_ in the next cycle.
//  - Stall: the result register holds while rsp_ready is low; req_ready
//    stays high as long as the result register is empty or drains in the
//    same cycle, so a stalled receiver backs up the byte stream by one beat.
//  - Reset: column 0, start of column, error cleared, column count 1,
//    class tables 0, result register empty. Once an unsupported class is
//    seen, bytes are taken and dropped until the next reset.
`timescale 1ns / 1ps
`default_nettype none
module tds_row_value_deframer
   import tdsrv_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS = 32
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_data_byte,

   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [1:0]                  rsp_kind,
   output logic [7:0]                  rsp_value_byte,
   output logic [COL_W-1:0]            rsp_column_index,
   output logic                        rsp_last_of_value,
   output logic                        rsp_last_of_row,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [TABLE_W-1:0]     csr_data
);

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_COLUMNS);

   logic [COUNT_W-1:0]   count_ff;
   logic [TABLE_W-1:0]   class_low_ff;
   logic [TABLE_W-1:0]   class_high_ff;
   parse_state_type      state_ff, state_in;
   result_type           step_res;
   result_type           rsp_ff;
   logic                 rsp_valid_ff;

   logic                 req_accept;
   logic                 csr_accept;
   logic [COUNT_W-1:0]   eff_count;
   logic [2*TABLE_W-1:0] class_table;
   logic [CLASS_W-1:0]   col_class;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      eff_count = count_ff;
      if (eff_count == '0) begin
         eff_count = COUNT_W'(1);
      end
      if (eff_count > MAX_COUNT) begin
         eff_count = MAX_COUNT;
      end
   end

   assign class_table = {class_high_ff, class_low_ff};
   assign col_class   = class_table[{state_ff.column, 2'b00} +: CLASS_W];

   tdsrv_step u_step (
      .cur       (state_ff),
      .data_byte (req_data_byte),
      .col_class (col_class),
      .eff_count (eff_count),
      .nxt       (state_in),
      .res       (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= COUNT_W'(1);
         class_low_ff  <= '0;
         class_high_ff <= '0;
      end else if (csr_accept) begin
         unique case (csr_index)
            CSR_COLUMN_COUNT: count_ff      <= csr_data[COUNT_W-1:0];
            CSR_CLASS_LOW:    class_low_ff  <= csr_data;
            CSR_CLASS_HIGH:   class_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{column: '0, phase: PH_START, bytes_left: '0,
                       prefix_low: '0, error: 1'b0};
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // result register: load on a producing beat, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && step_res.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && step_res.valid) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_ff.kind;
   assign rsp_value_byte    = rsp_ff.value_byte;
   assign rsp_column_index  = rsp_ff.column_index;
   assign rsp_last_of_value = rsp_ff.last_of_value;
   assign rsp_last_of_row   = rsp_ff.last_of_row;

   a_error_sticky : assert property (@(posedge clock) disable iff (reset)
      state_ff.error |=> state_ff.error)
      else $error("error flag cleared without reset");

   a_error_sets_flag : assert property (@(posedge clock) disable iff (reset)
      (req_accept && step_res.valid && step_res.kind == KIND_ERROR) |=> state_ff.error)
      else $error("error result without latched error");

   a_no_result_after_error : assert property (@(posedge clock) disable iff (reset)
      state_ff.error |-> !step_res.valid)
      else $error("result produced after latched error");

   a_payload_nonzero : assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_PAYLOAD) |-> (state_ff.bytes_left != '0))
      else $error("payload phase with no bytes left");

   a_row_end_ends_value : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_row) |-> rsp_last_of_value)
      else $error("row end without value end");

endmodule
`default_nettype wire
